FILE: sv/bclru_pkg.sv
// package: widths, function codes, status codes and the request and result structs of the block cache table
`default_nettype none
package bclru_pkg;
    localparam int Entries   = 16;
    localparam int AddrBits  = 48;
    localparam int SlotBits  = $clog2(Entries);
    localparam int CountBits = $clog2(Entries + 1);
    localparam int QDepth    = 2;

    typedef enum logic [2:0] {
        FN_ACCESS = 3'd0, FN_EVICT = 3'd1, FN_PIN = 3'd2, FN_UNPIN = 3'd3,
        FN_DIRTY = 3'd4, FN_WDONE = 3'd5, FN_STAT = 3'd6, FN_NONE = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0, ST_INSERT = 2'd1, ST_NOROOM = 2'd2, ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_func                 func;
        logic [AddrBits-1:0]   base;
        logic [5:0]            offset;
        logic                  keep;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [SlotBits-1:0]   slot;
        logic [5:0]            offset;
        logic                  vvalid;
        logic [AddrBits-1:0]   vlba;
        logic [CountBits-1:0]  present;
        logic [CountBits-1:0]  dirty;
    } t_res;
endpackage
`default_nettype wire

FILE: sv/bclru_front.sv
// front: takes requests, aligns the address to its block and queues the request
`default_nettype none
module bclru_front import bclru_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [2:0]    i_func,
    input  wire logic [AddrBits-1:0] i_lba,
    input  wire logic          i_keep,
    input  wire logic [2:0]    i_shift,
    output logic               o_q_valid,
    input  wire logic          i_q_take,
    output t_req               o_q_req
);
    t_req r_q [QDepth];
    logic r_rd, r_wr;
    logic [1:0] r_cnt;
    logic [2:0] w_sh;
    logic [AddrBits-1:0] w_low;
    t_req w_req;

    always_comb begin
        w_sh  = (i_shift > 3'd6) ? 3'd6 : i_shift;
        w_low = (AddrBits'(1) << w_sh) - AddrBits'(1);
        w_req.func   = t_func'(i_func);
        w_req.base   = i_lba & ~w_low;
        w_req.offset = 6'(i_lba & w_low);
        w_req.keep   = i_keep;
    end

    assign o_ready   = (r_cnt != 2'(QDepth));
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_q[r_wr] <= w_req;
        if (!i_rst_n) begin
            r_rd <= 1'b0; r_wr <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wr <= ~r_wr;
            if (i_q_take) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(i_q_take);
        end
    end

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_take |-> o_q_valid) else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDepth)) else $error("queue count overflow");
    a_full_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QDepth)) |-> !o_ready) else $error("ready while full");
endmodule
`default_nettype wire

FILE: sv/bclru_back.sv
// back: scans the table one slot a cycle, then updates it and produces the result
`default_nettype none
module bclru_back import bclru_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    output logic       o_q_take,
    input  wire t_req  i_q_req,
    output logic       o_res_valid,
    input  wire logic  i_res_ready,
    output t_res       o_res
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001, S_SCAN = 3'b010, S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_req r_req;
    logic [SlotBits:0] r_idx;
    logic [Entries-1:0] r_valid;
    logic [AddrBits-1:0] r_tag [Entries];
    logic [31:0] r_stamp [Entries];
    logic [Entries-1:0] r_res_flag, r_dirty;
    logic [7:0] r_pin [Entries];
    logic [31:0] r_tick;

    logic r_hit, r_free, r_vic;
    logic [SlotBits-1:0] r_hit_s, r_free_s, r_vic_s;
    logic [31:0] r_vic_stamp;
    logic [CountBits-1:0] r_pres, r_drt;
    logic r_out_v;
    t_res r_out;
    t_res n_out;

    logic [SlotBits-1:0] w_i;
    logic w_elig;

    assign w_i = r_idx[SlotBits-1:0];
    assign w_elig = r_valid[w_i] && !r_res_flag[w_i] && (r_pin[w_i] == 8'd0);
    assign o_q_take = (r_state == S_IDLE) && i_q_valid && !r_out_v;
    assign o_res_valid = r_out_v;
    assign o_res = r_out;

    // result word built from the scan outcome
    always_comb begin
        n_out = '0;
        n_out.status = ST_DONE;
        case (r_req.func)
            FN_ACCESS: begin
                n_out.offset = r_req.offset;
                if (r_hit) begin
                    n_out.slot = r_hit_s;
                end else if (r_free) begin
                    n_out.slot = r_free_s;
                    n_out.status = ST_INSERT;
                end else if (r_vic) begin
                    n_out.slot = r_vic_s;
                    n_out.vvalid = 1'b1;
                    n_out.vlba = r_tag[r_vic_s];
                    n_out.status = ST_INSERT;
                end else begin
                    n_out.status = ST_NOROOM;
                end
            end
            FN_EVICT: begin
                if (r_vic) begin
                    n_out.slot = r_vic_s; n_out.vvalid = 1'b1;
                    n_out.vlba = r_tag[r_vic_s];
                end else begin
                    n_out.status = ST_NOTFOUND;
                end
            end
            FN_PIN, FN_UNPIN, FN_DIRTY, FN_WDONE: begin
                n_out.offset = r_req.offset;
                if (!r_hit) n_out.status = ST_NOTFOUND;
                else n_out.slot = r_hit_s;
            end
            FN_STAT: begin
                n_out.present = r_pres; n_out.dirty = r_drt;
            end
            default: n_out.status = ST_NOTFOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_tick <= '0; r_out_v <= 1'b0;
            r_idx <= '0;
        end else begin
            if (r_out_v && i_res_ready) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_q_take) begin
                        r_req <= i_q_req; r_idx <= '0;
                        r_hit <= 1'b0; r_free <= 1'b0; r_vic <= 1'b0;
                        r_hit_s <= '0; r_free_s <= '0; r_vic_s <= '0;
                        r_vic_stamp <= '0; r_pres <= '0; r_drt <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one slot per cycle through the shared compare
                    if (r_valid[w_i] && r_tag[w_i] == r_req.base && !r_hit) begin
                        r_hit <= 1'b1; r_hit_s <= w_i;
                    end
                    if (!r_valid[w_i] && !r_free) begin
                        r_free <= 1'b1; r_free_s <= w_i;
                    end
                    if (w_elig && (!r_vic || r_stamp[w_i] < r_vic_stamp)) begin
                        r_vic <= 1'b1; r_vic_s <= w_i; r_vic_stamp <= r_stamp[w_i];
                    end
                    if (r_valid[w_i]) begin
                        r_pres <= r_pres + CountBits'(1);
                        if (r_dirty[w_i]) r_drt <= r_drt + CountBits'(1);
                    end
                    r_idx <= r_idx + (SlotBits+1)'(1);
                    if (r_idx == (SlotBits+1)'(Entries - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out <= n_out;
                    case (r_req.func)
                        FN_ACCESS: begin
                            if (r_hit) begin
                                r_stamp[r_hit_s] <= r_tick; r_tick <= r_tick + 32'd1;
                            end else if (r_free || r_vic) begin
                                if (r_free) begin
                                    r_valid[r_free_s] <= 1'b1;
                                    r_tag[r_free_s] <= r_req.base;
                                    r_stamp[r_free_s] <= r_tick;
                                    r_res_flag[r_free_s] <= r_req.keep;
                                    r_dirty[r_free_s] <= 1'b0;
                                    r_pin[r_free_s] <= 8'd0;
                                end else begin
                                    r_tag[r_vic_s] <= r_req.base;
                                    r_stamp[r_vic_s] <= r_tick;
                                    r_res_flag[r_vic_s] <= r_req.keep;
                                    r_dirty[r_vic_s] <= 1'b0;
                                    r_pin[r_vic_s] <= 8'd0;
                                end
                                r_tick <= r_tick + 32'd1;
                            end
                        end
                        FN_EVICT: begin
                            if (r_vic) r_valid[r_vic_s] <= 1'b0;
                        end
                        FN_PIN, FN_UNPIN, FN_DIRTY, FN_WDONE: begin
                            if (r_hit) begin
                                if (r_req.func == FN_PIN || r_req.func == FN_DIRTY) begin
                                    if (r_pin[r_hit_s] != 8'hff)
                                        r_pin[r_hit_s] <= r_pin[r_hit_s] + 8'd1;
                                    if (r_req.func == FN_DIRTY) r_dirty[r_hit_s] <= 1'b1;
                                end else begin
                                    if (r_pin[r_hit_s] != 8'd0)
                                        r_pin[r_hit_s] <= r_pin[r_hit_s] - 8'd1;
                                    if (r_req.func == FN_WDONE) r_dirty[r_hit_s] <= 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_v) else $error("no result after scan");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_take |=> (r_state == S_SCAN)) else $error("take did not start scan");
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_hit) |-> r_valid[r_hit_s]) else $error("hit on empty slot");
endmodule
`default_nettype wire

FILE: sv/block_cache_lru_table.sv
// block cache tag table with LRU replacement
// Requests enter on the s_axis channel (tdata: lba then keep_resident, tuser: func).
// Results leave on m_axis (tdata: status, slot, sector_offset, victim_valid,
// victim_lba, present_count, dirty_count from the lowest bit up).
// block_shift is to be written on the cfg channel while the block is idle; the
// block itself does not enforce this. A front stage aligns the address and
// queues up to two words; the back part scans all 16 slots with one compare
// unit, one slot a cycle, then updates the table and builds the result word. A
// new request is taken from the queue only after the previous result word has
// been taken by the receiver.
// The result stays in its output register until taken; while the receiver
// stalls, the front still accepts words until its queue is full.
// Reset empties the table, zeroes the use tick and sets block_shift to 3.
`default_nettype none
module block_cache_lru_table import bclru_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // lba[47:0], keep_resident[48]
    input  wire logic [2:0]  s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // status, slot, offset, vvalid, vlba, present, dirty
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_data
);
    logic [2:0] r_shift;
    logic w_qv, w_take;
    t_req w_qreq;
    t_res w_res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_shift <= 3'd3;
        else if (i_cfg_valid) r_shift <= i_cfg_data;
    end

    bclru_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_func(s_axis_tuser), .i_lba(s_axis_tdata[AddrBits-1:0]),
        .i_keep(s_axis_tdata[48]), .i_shift(r_shift),
        .o_q_valid(w_qv), .i_q_take(w_take), .o_q_req(w_qreq)
    );

    bclru_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_qv), .o_q_take(w_take), .i_q_req(w_qreq),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {1'b0, w_res.dirty, w_res.present, w_res.vlba, w_res.vvalid,
                           w_res.offset, w_res.slot, w_res.status};
endmodule
`default_nettype wire
